/* src/sfla_pkg.sv */
// Shared definitions for the slab free-list allocator.
// Field widths, request and status codes. No dependencies.
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int HANDLE_W = 9;
  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FAIL     = 2'd1;
  localparam status_t ST_BAD_FREE = 2'd2;

endpackage

/* src/sfla_if.sv */
// Channel interfaces for the slab free-list allocator: request, result, config.
// Depends on sfla_pkg for field widths.
`timescale 1ns / 1ps

interface sfla_req_if;
  import sfla_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [HANDLE_W-1:0] free_handle;
  logic [ADDR_W-1:0]   offered_frame;

  modport source (output valid, req_type, free_handle, offered_frame, input ready);
  modport sink   (input valid, req_type, free_handle, offered_frame, output ready);
endinterface

interface sfla_res_if;
  import sfla_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [HANDLE_W-1:0] slot_handle;
  logic [ADDR_W-1:0]   slot_address;
  logic                frame_taken;
  logic [COUNT_W-1:0]  free_total;
  logic [COUNT_W-1:0]  slot_total;
  logic [COUNT_W-1:0]  in_use_total;

  modport source (output valid, status, slot_handle, slot_address, frame_taken,
                  free_total, slot_total, in_use_total, input ready);
  modport sink   (input valid, status, slot_handle, slot_address, frame_taken,
                  free_total, slot_total, in_use_total, output ready);
endinterface

interface sfla_cfg_if;
  import sfla_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/sfla_handle_decode.sv */
// Three-stage handle decoder: splits a slot handle into page index and slot.
// Reciprocal multiply, back-multiply, then one correction step. Uses sfla_pkg.
`timescale 1ns / 1ps

module sfla_handle_decode #(
  parameter int IDX_W = 9,
  parameter int SPP   = 32,
  parameter int PG_W  = 4,
  parameter int SL_W  = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IDX_W-1:0] handle,
  output logic             done,
  output logic [PG_W-1:0]  page,
  output logic [SL_W-1:0]  slot
);
  import sfla_pkg::*;

  localparam int RECIP = (1 << IDX_W) / SPP;
  localparam int RW    = IDX_W + 1;
  localparam int PW    = IDX_W + RW;
  localparam int SPW   = $clog2(SPP + 1);
  localparam int MW    = IDX_W + SPW;

  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  logic [IDX_W-1:0] h1_r, q1_r, q2_r, r2_r;
  logic [PW-1:0]    prod1;
  logic [MW-1:0]    prod2;
  logic [PG_W-1:0]  page_r;
  logic [SL_W-1:0]  slot_r;

  // estimate quotient, never above the true value and at most one below
  assign prod1 = PW'(handle) * PW'(RECIP);
  // back-multiply the estimate
  assign prod2 = MW'(q1_r) * MW'(SPP);

  assign v1_nxt = start;
  assign v2_nxt = v1_r;
  assign v3_nxt = v2_r;

  // advance the valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // datapath stages; outputs hold until the next start
  always_ff @(posedge clk) begin
    if (start) begin
      h1_r <= handle;
      q1_r <= prod1[PW-2 -: IDX_W];
    end
    if (v1_r) begin
      q2_r <= q1_r;
      r2_r <= IDX_W'(MW'(h1_r) - prod2);
    end
    if (v2_r) begin
      if (r2_r >= SPP) begin
        page_r <= PG_W'(q2_r + 1'b1);
        slot_r <= SL_W'(r2_r - SPP);
      end else begin
        page_r <= PG_W'(q2_r);
        slot_r <= SL_W'(r2_r);
      end
    end
  end

  assign done = v3_r;
  assign page = page_r;
  assign slot = slot_r;

endmodule

/* src/slab_free_list_allocator.sv */
// Slab free-list allocator. Free or refused allocate: from acceptance through S_DONE into the
// output register. Allocate: link read, 3-stage decode with the frame read on its last cycle,
// two adds, output load; when a page is linked in, its slots are first chained in S_GROW.
// One transaction at a time; an output stall holds the transaction in S_DONE.
// Reset is synchronous, active low; link and frame stores are not cleared.
// Depends on sfla_pkg, sfla_if and sfla_handle_decode.
`timescale 1ns / 1ps

module slab_free_list_allocator #(
  parameter int MAX_PAGES  = 16,
  parameter int PAGE_SLOTS = 32,
  parameter int SLOT_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  sfla_req_if.sink   in_if,
  sfla_res_if.source out_if,
  sfla_cfg_if.sink   cfg_if
);
  import sfla_pkg::*;

  localparam int CAP    = MAX_PAGES * PAGE_SLOTS;
  localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PO_W   = $clog2(MAX_PAGES + 1);
  localparam int SL_W   = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CMP_W  = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
  localparam int OFF_W  = SL_W + 13;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GROW = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_SUM1 = 3'd4;
  localparam logic [2:0] S_SUM2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [PO_W-1:0]  pages_r, pages_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] page_base_r, page_base_nxt;
  logic [SL_W-1:0]  grow_i_r, grow_i_nxt;
  logic [ADDR_W-1:0] map_base_r, map_base_nxt;
  logic             out_valid_r, out_valid_nxt;

  // per-transaction payload
  status_t          res_status_r;
  logic [IDX_W-1:0] res_handle_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic             res_taken_r;
  logic [ADDR_W-1:0] sum1_r;
  logic [OFF_W-1:0] off_r;

  status_t             out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_taken_r;
  logic [COUNT_W-1:0]  out_free_r, out_slot_r, out_use_r;

  // stores
  logic [IDX_W-1:0]  link_mem [CAP];
  logic [ADDR_W-1:0] frame_mem [MAX_PAGES];
  logic [IDX_W-1:0]  link_rdata;
  logic [ADDR_W-1:0] frame_rdata;

  logic             link_we, link_re, frame_we, frame_re;
  logic [IDX_W-1:0] link_waddr, link_wdata;
  logic [PG_W-1:0]  frame_waddr;

  logic             in_acc, load_out, bad_free, refuse, grow_last, dec_start;
  logic [CNT_W-1:0] grow_addr;
  logic [IDX_W-1:0] fh_idx;

  logic             dec_done;
  logic [PG_W-1:0]  dec_page;
  logic [SL_W-1:0]  dec_slot;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && (state_r == S_IDLE);
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  assign bad_free  = (CMP_W'(in_if.free_handle) >= CMP_W'(total_r)) || (free_r >= total_r);
  assign refuse    = (in_if.offered_frame == '0) || (pages_r >= MAX_PAGES);
  assign fh_idx    = IDX_W'(CMP_W'(in_if.free_handle));
  assign grow_addr = page_base_r + CNT_W'(grow_i_r);
  assign grow_last = (grow_i_r == SL_W'(PAGE_SLOTS - 1));
  assign dec_start = (state_r == S_POP);

  // store port control
  always_comb begin
    link_we     = 1'b0;
    link_waddr  = head_r;
    link_wdata  = head_r;
    frame_we    = 1'b0;
    frame_waddr = PG_W'(pages_r);
    link_re     = (state_r == S_POP);
    frame_re    = (state_r == S_DEC) && dec_done;
    if (in_acc && in_if.req_type == REQ_FREE && !bad_free) begin
      link_we    = 1'b1;
      link_waddr = fh_idx;
      link_wdata = head_r;
    end
    if (in_acc && in_if.req_type == REQ_ALLOC && free_r == '0 && !refuse) begin
      frame_we = 1'b1;
    end
    if (state_r == S_GROW) begin
      link_we    = 1'b1;
      link_waddr = IDX_W'(grow_addr);
      link_wdata = grow_last ? head_r : IDX_W'(grow_addr + 1'b1);
    end
  end

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    pages_nxt     = pages_r;
    free_nxt      = free_r;
    total_nxt     = total_r;
    page_base_nxt = page_base_r;
    grow_i_nxt    = grow_i_r;
    map_base_nxt  = cfg_if.valid ? cfg_if.data : map_base_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.req_type == REQ_FREE) begin
            if (!bad_free) begin
              head_nxt = fh_idx;
              free_nxt = free_r + 1'b1;
            end
            state_nxt = S_DONE;
          end else if (free_r != '0) begin
            state_nxt = S_POP;
          end else if (refuse) begin
            state_nxt = S_DONE;
          end else begin
            grow_i_nxt = '0;
            state_nxt  = S_GROW;
          end
        end
      end
      S_GROW: begin
        grow_i_nxt = SL_W'(grow_i_r + 1'b1);
        if (grow_last) begin
          head_nxt      = IDX_W'(page_base_r);
          pages_nxt     = PO_W'(pages_r + 1'b1);
          page_base_nxt = CNT_W'(page_base_r + CNT_W'(PAGE_SLOTS));
          free_nxt      = CNT_W'(free_r + CNT_W'(PAGE_SLOTS));
          total_nxt     = CNT_W'(total_r + CNT_W'(PAGE_SLOTS));
          state_nxt     = S_POP;
        end
      end
      S_POP:  state_nxt = S_DEC;
      S_DEC: begin
        if (dec_done) begin
          head_nxt  = link_rdata;
          free_nxt  = free_r - 1'b1;
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: state_nxt = S_SUM2;
      S_SUM2: state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      pages_r     <= '0;
      free_r      <= '0;
      total_r     <= '0;
      page_base_r <= '0;
      grow_i_r    <= '0;
      map_base_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      pages_r     <= pages_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      page_base_r <= page_base_nxt;
      grow_i_r    <= grow_i_nxt;
      map_base_r  <= map_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: capture per phase of the transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_handle_r <= '0;
      res_addr_r   <= '0;
      res_taken_r  <= 1'b0;
      if (in_if.req_type == REQ_FREE) begin
        res_status_r <= bad_free ? ST_BAD_FREE : ST_OK;
      end else if (free_r == '0 && refuse) begin
        res_status_r <= ST_FAIL;
      end else begin
        res_status_r <= ST_OK;
        res_taken_r  <= (free_r == '0);
      end
    end
    if (state_r == S_POP) begin
      res_handle_r <= head_r;
    end
    if (state_r == S_SUM1) begin
      sum1_r <= map_base_r + frame_rdata;
      off_r  <= OFF_W'(dec_slot) * OFF_W'(SLOT_BYTES);
    end
    if (state_r == S_SUM2) begin
      res_addr_r <= sum1_r + ADDR_W'(off_r);
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_handle_r <= HANDLE_W'(res_handle_r);
      out_addr_r   <= res_addr_r;
      out_taken_r  <= res_taken_r;
      out_free_r   <= COUNT_W'(free_r);
      out_slot_r   <= COUNT_W'(total_r);
      out_use_r    <= COUNT_W'(total_r - free_r);
    end
  end

  // link store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[head_r];
    end
  end

  // page frame store
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= in_if.offered_frame;
    end
    if (frame_re) begin
      frame_rdata <= frame_mem[dec_page];
    end
  end

  sfla_handle_decode #(
    .IDX_W (IDX_W),
    .SPP   (PAGE_SLOTS),
    .PG_W  (PG_W),
    .SL_W  (SL_W)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dec_start),
    .handle (head_r),
    .done   (dec_done),
    .page   (dec_page),
    .slot   (dec_slot)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.slot_handle  = out_handle_r;
  assign out_if.slot_address = out_addr_r;
  assign out_if.frame_taken  = out_taken_r;
  assign out_if.free_total   = out_free_r;
  assign out_if.slot_total   = out_slot_r;
  assign out_if.in_use_total = out_use_r;

endmodule

/* src/sfla_checker.sv */
// Port-level checks for the slab free-list allocator, bound to the top level.
// Depends on sfla_pkg and slab_free_list_allocator.
`timescale 1ns / 1ps

module sfla_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input sfla_pkg::status_t             status,
  input logic [sfla_pkg::HANDLE_W-1:0] slot_handle,
  input logic [sfla_pkg::ADDR_W-1:0]   slot_address,
  input logic                          frame_taken,
  input logic [sfla_pkg::COUNT_W-1:0]  free_total,
  input logic [sfla_pkg::COUNT_W-1:0]  slot_total,
  input logic [sfla_pkg::COUNT_W-1:0]  in_use_total
);
  import sfla_pkg::*;

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request channel ready straight after a transaction");

  // hold a stalled result
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({status, slot_handle, slot_address,
      frame_taken, free_total, slot_total, in_use_total}))
    else $error("stalled result changed");

  // a refused allocation hands out nothing
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FAIL |-> slot_handle == '0 && slot_address == '0 &&
      !frame_taken)
    else $error("failed allocation carries a slot");

  // counts stay consistent
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_use_total == COUNT_W'(slot_total - free_total))
    else $error("in-use count mismatch");

  // drop the result register on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .status       (out_if.status),
  .slot_handle  (out_if.slot_handle),
  .slot_address (out_if.slot_address),
  .frame_taken  (out_if.frame_taken),
  .free_total   (out_if.free_total),
  .slot_total   (out_if.slot_total),
  .in_use_total (out_if.in_use_total)
);
